FILE: sv/gn2_pkg.sv
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared constants and helper functions for the 2D gradient-noise sampler.
// ----------------------------------------------------------------------------
package gn2_pkg;

   localparam logic [31:0] MIX_K0 = 32'd3284157443;
   localparam logic [31:0] MIX_K1 = 32'd1911520717;
   localparam logic [31:0] MIX_K2 = 32'd2048419325;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // (2n)(2n+1) for n = 1..7
   localparam longint unsigned TAYLOR_DIV [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   localparam int NOISE_W   = 17;
   localparam int GRAD_W    = 16;
   localparam int SINE_W    = 15;
   localparam int OUT_MIN   = -65536;
   localparam int OUT_MAX   = 65535;

   function automatic logic [31:0] rot16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   // Quarter-wave sine sample k of 2^(ab-2) steps, Q15, Taylor series to t^15.
   // Only evaluated at elaboration to fill the gradient table.
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                       input int unsigned ab);
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint          r;
      t    = (longint'(k) * PI_HALF_Q30) >> (ab - 2);
      t2   = (t * t) >> 30;
      term = t;
      sum  = longint'(t);
      for (int n = 0; n < 7; n++) begin
         term = ((term * t2) >> 30) / TAYLOR_DIV[n];
         if (n % 2 == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return SINE_W'(r);
   endfunction

endpackage

FILE: sv/gn2_req_if.sv
// ----------------------------------------------------------------------------
// gn2_req_if
// Sample point channel: one (x, y) item in signed Q16.16 per handshake.
// ----------------------------------------------------------------------------
interface gn2_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;

   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

FILE: sv/gn2_rsp_if.sv
// ----------------------------------------------------------------------------
// gn2_rsp_if
// Noise result channel: one signed Q2.15 value per item.
// ----------------------------------------------------------------------------
interface gn2_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

FILE: sv/gn2_hash.sv
// ----------------------------------------------------------------------------
// gn2_hash
// Three-stage corner hash: multiply, rotate-by-16 and xor, one multiply a stage.
// ----------------------------------------------------------------------------
module gn2_hash
   import gn2_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] cx,
   input  logic [31:0] cy,
   output logic [31:0] hash
);

   logic [31:0] a_ff, a_in;
   logic [31:0] cy_ff;
   logic [31:0] b_ff, b_in;
   logic [31:0] a2_ff;
   logic [31:0] h_ff, h_in;

   assign a_in = cx * MIX_K0;
   assign b_in = (cy_ff ^ rot16(a_ff)) * MIX_K1;
   assign h_in = (a2_ff ^ rot16(b_ff)) * MIX_K2;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff  <= a_in;
         cy_ff <= cy;
         b_ff  <= b_in;
         a2_ff <= a_ff;
         h_ff  <= h_in;
      end
   end

   assign hash = h_ff;

endmodule

FILE: sv/gn2_grad.sv
// ----------------------------------------------------------------------------
// gn2_grad
// Gradient lookup: quarter-wave sine table with quadrant folding, registered.
// ----------------------------------------------------------------------------
module gn2_grad
   import gn2_pkg::*;
#(
   parameter int ANGLE_BITS = 10
)
(
   input  logic                     clock,
   input  logic                     en,
   input  logic [ANGLE_BITS-1:0]    idx,
   output logic signed [GRAD_W-1:0] gx,
   output logic signed [GRAD_W-1:0] gy
);

   localparam int QUARTER = 2 ** (ANGLE_BITS - 2);

   logic [SINE_W-1:0] sine_rom [QUARTER+1];

   for (genvar gk = 0; gk <= QUARTER; gk++) begin : g_rom
      assign sine_rom[gk] = quarter_sine(gk, ANGLE_BITS);
   end

   logic [1:0]                quad;
   logic [ANGLE_BITS-3:0]     rem;
   logic [ANGLE_BITS-2:0]     cidx;
   logic signed [GRAD_W-1:0]  sr, cr;
   logic signed [GRAD_W-1:0]  gx_ff, gx_in, gy_ff, gy_in;

   assign quad = idx[ANGLE_BITS-1 -: 2];
   assign rem  = idx[ANGLE_BITS-3:0];
   assign cidx = (ANGLE_BITS-1)'(QUARTER) - {1'b0, rem};
   assign sr   = $signed({1'b0, sine_rom[{1'b0, rem}]});
   assign cr   = $signed({1'b0, sine_rom[cidx]});

   always_comb begin
      unique case (quad)
         2'd0: begin gx_in = sr;  gy_in = cr;  end
         2'd1: begin gx_in = cr;  gy_in = -sr; end
         2'd2: begin gx_in = -sr; gy_in = -cr; end
         default: begin gx_in = -cr; gy_in = sr; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign gx = gx_ff;
   assign gy = gy_ff;

endmodule

FILE: sv/gradient_noise_2d_sample.sv
// Throughput: one item per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place.
// The pipeline has eleven stages: lattice split, three hash multiplies, table lookup,
//   gradient products, dot sums, then a multiply and an add per blend axis.
// Reset: synchronous, clears all stage valid bits; data registers not reset.
// ----------------------------------------------------------------------------
// gradient_noise_2d_sample
// 2D gradient noise: corner hash, gradient table, dots, smoothstep blend.
// ----------------------------------------------------------------------------
module gradient_noise_2d_sample
   import gn2_pkg::*;
#(
   parameter int ANGLE_BITS = 10,
   parameter int FRAC_BITS  = 16
)
(
   input logic       clock,
   input logic       reset,
   gn2_req_if.sink   req,
   gn2_rsp_if.source rsp
);

   localparam int F     = FRAC_BITS;
   localparam int NST   = 11;
   localparam int PDW   = F + 17;          // gradient * offset product
   localparam int DW    = 20;              // dots and blend values
   localparam int PW    = DW + 1 + F + 2;  // blend product
   localparam int FADE3 = 3 * (2 ** F);

   logic           en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[NST-1] || rsp.ready;
   assign req.ready = en;
   assign vld_in    = {vld_ff[NST-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---- stage 0: lattice corners and fractions
   logic [31:0]  cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic [31:0]  cx0_in, cy0_in;
   logic [F-1:0] fx_ff [5];
   logic [F-1:0] fy_ff [5];

   assign cx0_in = 32'($signed(req.x_pos) >>> F);
   assign cy0_in = 32'($signed(req.y_pos) >>> F);

   always_ff @(posedge clock) begin
      if (en) begin
         cx0_ff   <= cx0_in;
         cx1_ff   <= cx0_in + 32'd1;
         cy0_ff   <= cy0_in;
         cy1_ff   <= cy0_in + 32'd1;
         fx_ff[0] <= req.x_pos[F-1:0];
         fy_ff[0] <= req.y_pos[F-1:0];
         for (int i = 1; i < 5; i++) begin
            fx_ff[i] <= fx_ff[i-1];
            fy_ff[i] <= fy_ff[i-1];
         end
      end
   end

   // ---- stages 1..3: hashes, 4: gradients
   logic [31:0]               hash [4];
   logic signed [GRAD_W-1:0]  gx [4];
   logic signed [GRAD_W-1:0]  gy [4];

   for (genvar gc = 0; gc < 4; gc++) begin : g_corner
      gn2_hash u_hash (
         .clock (clock),
         .en    (en),
         .cx    ((gc % 2 == 0) ? cx0_ff : cx1_ff),
         .cy    ((gc < 2) ? cy0_ff : cy1_ff),
         .hash  (hash[gc])
      );
      gn2_grad #(.ANGLE_BITS(ANGLE_BITS)) u_grad (
         .clock (clock),
         .en    (en),
         .idx   (hash[gc][31 -: ANGLE_BITS]),
         .gx    (gx[gc]),
         .gy    (gy[gc])
      );
   end

   // ---- stages 1..2: smoothstep weights
   logic [F-1:0]   w2x_ff, w2y_ff, w2x_in, w2y_in;
   logic [2*F-1:0] sqx, sqy;
   logic [F+1:0]   trix, triy;
   logic [3*F+1:0] fdx, fdy;
   logic [F:0]     sx_ff [2:6];
   logic [F:0]     sy_ff [2:8];

   assign sqx    = fx_ff[0] * fx_ff[0];
   assign sqy    = fy_ff[0] * fy_ff[0];
   assign w2x_in = sqx[2*F-1:F];
   assign w2y_in = sqy[2*F-1:F];
   assign trix   = (F+2)'(FADE3) - {1'b0, fx_ff[1], 1'b0};
   assign triy   = (F+2)'(FADE3) - {1'b0, fy_ff[1], 1'b0};
   assign fdx    = w2x_ff * trix;
   assign fdy    = w2y_ff * triy;

   always_ff @(posedge clock) begin
      if (en) begin
         w2x_ff   <= w2x_in;
         w2y_ff   <= w2y_in;
         sx_ff[2] <= fdx[2*F:F];
         sy_ff[2] <= fdy[2*F:F];
         for (int i = 3; i <= 6; i++) begin
            sx_ff[i] <= sx_ff[i-1];
         end
         for (int i = 3; i <= 8; i++) begin
            sy_ff[i] <= sy_ff[i-1];
         end
      end
   end

   // ---- stage 5: gradient * offset products, 6: dots
   logic signed [F:0]     dx [4];
   logic signed [F:0]     dy [4];
   logic signed [PDW-1:0] px_ff [4];
   logic signed [PDW-1:0] py_ff [4];
   logic signed [PDW-1:0] px_in [4];
   logic signed [PDW-1:0] py_in [4];
   logic signed [PDW:0]   dsum [4];
   logic signed [DW-1:0]  dot_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         // high corner offset is frac - 1.0: same bits with the sign bit set
         dx[c]    = $signed({(c % 2 == 1) ? 1'b1 : 1'b0, fx_ff[4]});
         dy[c]    = $signed({(c >= 2) ? 1'b1 : 1'b0, fy_ff[4]});
         px_in[c] = PDW'(gx[c]) * PDW'(dx[c]);
         py_in[c] = PDW'(gy[c]) * PDW'(dy[c]);
         dsum[c]  = (PDW+1)'(px_ff[c]) + (PDW+1)'(py_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            px_ff[c]  <= px_in[c];
            py_ff[c]  <= py_in[c];
            dot_ff[c] <= DW'(dsum[c] >>> F);
         end
      end
   end

   // ---- stages 7..8: blend along x, 9..10: blend along y and saturate
   logic signed [PW-1:0]  ptop_ff, pbot_ff, ptop_in, pbot_in;
   logic signed [DW-1:0]  tl_ff, bl_ff;
   logic signed [DW-1:0]  top_ff, bot_ff, top_in, bot_in;
   logic signed [PW-1:0]  pv_ff, pv_in;
   logic signed [DW-1:0]  top2_ff;
   logic signed [DW:0]    v_sum;
   logic signed [NOISE_W-1:0] out_ff, out_in;

   assign ptop_in = PW'(DW'(dot_ff[1]) - DW'(dot_ff[0]) + (DW+1)'(0)) *
                    PW'($signed({1'b0, sx_ff[6]}));
   assign pbot_in = PW'(DW'(dot_ff[3]) - DW'(dot_ff[2]) + (DW+1)'(0)) *
                    PW'($signed({1'b0, sx_ff[6]}));
   assign top_in  = tl_ff + DW'(ptop_ff >>> F);
   assign bot_in  = bl_ff + DW'(pbot_ff >>> F);
   assign pv_in   = PW'((DW+1)'(bot_ff) - (DW+1)'(top_ff)) *
                    PW'($signed({1'b0, sy_ff[8]}));
   assign v_sum   = (DW+1)'(top2_ff) + (DW+1)'(pv_ff >>> F);

   always_comb begin
      priority if (v_sum < (DW+1)'(OUT_MIN)) begin
         out_in = NOISE_W'(OUT_MIN);
      end else if (v_sum > (DW+1)'(OUT_MAX)) begin
         out_in = NOISE_W'(OUT_MAX);
      end else begin
         out_in = NOISE_W'(v_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ptop_ff <= ptop_in;
         pbot_ff <= pbot_in;
         tl_ff   <= dot_ff[0];
         bl_ff   <= dot_ff[2];
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         pv_ff   <= pv_in;
         top2_ff <= top_ff;
         out_ff  <= out_in;
      end
   end

   assign rsp.valid       = vld_ff[NST-1];
   assign rsp.noise_value = out_ff;

   // ---- checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !en |-> vld_ff[NST-1])
      else $error("pipeline stalled with empty output register");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_item_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted item not in first stage");

   a_item_reaches_out: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[NST-2] |=> vld_ff[NST-1])
      else $error("item lost before output register");

endmodule
